@@ src/iau_pkg.sv @@
// ----------------------------------------------------------------------------
// iau_pkg
// Shared constants and types for the interval arithmetic unit.
// ----------------------------------------------------------------------------
package iau_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int RES_WIDTH  = 64;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic div_error;
		logic a_holds_b;
		logic b_holds_a;
		logic overlap;
		logic a_is_point;
	} flags_t;

endpackage

@@ src/iau_div.sv @@
// ----------------------------------------------------------------------------
// iau_div
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Carries a side tag alongside each request.
// ----------------------------------------------------------------------------
module iau_div #(
	parameter int W  = 33,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [W-1:0]  quo,
	output logic [TW-1:0] tag_out
);
	logic          v_q   [0:W];
	logic [W-1:0]  rem_q [0:W];
	logic [W-1:0]  q_q   [0:W];
	logic [W-1:0]  d_q   [0:W];
	logic          neg_q [0:W];
	logic [TW-1:0] t_q   [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= W; i++) v_q[i] <= 1'b0;
		end else begin
			v_q[0] <= in_valid;
			for (int i = 0; i < W; i++) v_q[i+1] <= v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= '0;
		q_q[0]   <= num[W-1] ? W'(-num) : num;
		d_q[0]   <= den[W-1] ? W'(-den) : den;
		neg_q[0] <= num[W-1] ^ den[W-1];
		t_q[0]   <= tag_in;
	end

	for (genvar g = 0; g < W; g++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] sh;
		assign sh    = {rem_q[g], q_q[g][W-1]};
		assign trial = sh - {1'b0, d_q[g]};
		always_ff @(posedge clk) begin
			if (!trial[W]) rem_q[g+1] <= trial[W-1:0];
			else           rem_q[g+1] <= sh[W-1:0];
			q_q[g+1]   <= {q_q[g][W-2:0], ~trial[W]};
			d_q[g+1]   <= d_q[g];
			neg_q[g+1] <= neg_q[g];
			t_q[g+1]   <= t_q[g];
		end
	end

	assign out_valid = v_q[W];
	assign quo       = neg_q[W] ? W'(-q_q[W]) : q_q[W];
	assign tag_out   = t_q[W];
endmodule

@@ src/iau_span.sv @@
// ----------------------------------------------------------------------------
// iau_span
// Registered min/max of four candidates in two stages.
// ----------------------------------------------------------------------------
module iau_span (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [iau_pkg::RES_WIDTH-1:0] v0,
	input  logic signed [iau_pkg::RES_WIDTH-1:0] v1,
	input  logic signed [iau_pkg::RES_WIDTH-1:0] v2,
	input  logic signed [iau_pkg::RES_WIDTH-1:0] v3,
	input  iau_pkg::flags_t                     flags_in,
	output logic                                out_valid,
	output logic signed [iau_pkg::RES_WIDTH-1:0] lo,
	output logic signed [iau_pkg::RES_WIDTH-1:0] hi,
	output iau_pkg::flags_t                     flags_out
);
	logic signed [iau_pkg::RES_WIDTH-1:0] lo0_s1, hi0_s1, lo1_s1, hi1_s1, lo_s2, hi_s2;
	logic v_s1, v_s2;
	iau_pkg::flags_t f_s1, f_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		lo0_s1 <= (v1 < v0) ? v1 : v0;
		hi0_s1 <= (v1 > v0) ? v1 : v0;
		lo1_s1 <= (v3 < v2) ? v3 : v2;
		hi1_s1 <= (v3 > v2) ? v3 : v2;
		f_s1   <= flags_in;
		lo_s2  <= (lo1_s1 < lo0_s1) ? lo1_s1 : lo0_s1;
		hi_s2  <= (hi1_s1 > hi0_s1) ? hi1_s1 : hi0_s1;
		f_s2   <= f_s1;
	end

	assign out_valid = v_s2;
	assign lo        = lo_s2;
	assign hi        = hi_s2;
	assign flags_out = f_s2;
endmodule

@@ src/interval_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// interval_arithmetic_unit
// Integer interval add, subtract, multiply and divide with relation flags.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op, a_lo, a_hi, b_lo, b_hi and pulse start. busy is always low, so
//   a request is taken every cycle that start is high.
//   Each request yields one result: res_lo, res_hi and the flags appear for
//   exactly one cycle with done high. The receiver cannot stall.
//   Every op travels the same path: stage 1 orders the endpoints, stage 2
//   forms sums, products and flags, then the divider pipeline (one quotient
//   bit per stage), then the min/max unit registers lo, hi and the flags.
//   Throughput: one per cycle.
//   Only DATA_WIDTH low bits of each endpoint are used, sign-extended.
//   Reset clears all valid bits; in-flight requests are dropped.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit #(
	parameter int DATA_WIDTH = iau_pkg::DATA_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          op,
	input  logic signed [31:0]                  a_lo,
	input  logic signed [31:0]                  a_hi,
	input  logic signed [31:0]                  b_lo,
	input  logic signed [31:0]                  b_hi,
	output logic                                done,
	output logic signed [iau_pkg::RES_WIDTH-1:0] res_lo,
	output logic signed [iau_pkg::RES_WIDTH-1:0] res_hi,
	output logic                                div_error,
	output logic                                a_holds_b,
	output logic                                b_holds_a,
	output logic                                overlap,
	output logic                                a_is_point
);
	localparam int RW = iau_pkg::RES_WIDTH;
	localparam int DW = DATA_WIDTH + 1;
	localparam int TW = 2 + 4 * RW + 5;

	assign busy = 1'b0;

	logic signed [DATA_WIDTH-1:0] al_w, ah_w, bl_w, bh_w;
	assign al_w = a_lo[DATA_WIDTH-1:0];
	assign ah_w = a_hi[DATA_WIDTH-1:0];
	assign bl_w = b_lo[DATA_WIDTH-1:0];
	assign bh_w = b_hi[DATA_WIDTH-1:0];

	// stage 1: order endpoints
	logic v_s1, v_s2;
	logic [1:0] op_s1, op_s2;
	logic signed [DATA_WIDTH-1:0] al_s1, ah_s1, bl_s1, bh_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		op_s1 <= op;
		al_s1 <= (ah_w < al_w) ? ah_w : al_w;
		ah_s1 <= (ah_w < al_w) ? al_w : ah_w;
		bl_s1 <= (bh_w < bl_w) ? bh_w : bl_w;
		bh_s1 <= (bh_w < bl_w) ? bl_w : bh_w;
	end

	// stage 2: products, sums, flags
	logic signed [RW-1:0] p0_s2, p1_s2, p2_s2, p3_s2;
	logic signed [DATA_WIDTH-1:0] al_s2, ah_s2, bl_s2, bh_s2;
	iau_pkg::flags_t f_s2;
	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		al_s2 <= al_s1;
		ah_s2 <= ah_s1;
		bl_s2 <= bl_s1;
		bh_s2 <= bh_s1;
		case (iau_pkg::op_t'(op_s1))
			iau_pkg::OP_ADD: begin
				p0_s2 <= RW'(al_s1) + RW'(bl_s1);
				p1_s2 <= RW'(ah_s1) + RW'(bh_s1);
				p2_s2 <= RW'(al_s1) + RW'(bl_s1);
				p3_s2 <= RW'(ah_s1) + RW'(bh_s1);
			end
			iau_pkg::OP_SUB: begin
				p0_s2 <= RW'(al_s1) - RW'(bh_s1);
				p1_s2 <= RW'(ah_s1) - RW'(bl_s1);
				p2_s2 <= RW'(al_s1) - RW'(bh_s1);
				p3_s2 <= RW'(ah_s1) - RW'(bl_s1);
			end
			default: begin
				p0_s2 <= RW'(al_s1) * RW'(bl_s1);
				p1_s2 <= RW'(al_s1) * RW'(bh_s1);
				p2_s2 <= RW'(ah_s1) * RW'(bl_s1);
				p3_s2 <= RW'(ah_s1) * RW'(bh_s1);
			end
		endcase
		f_s2.div_error  <= (op_s1 == iau_pkg::OP_DIV) && (bl_s1 <= 0) && (bh_s1 >= 0);
		f_s2.a_holds_b  <= (bl_s1 >= al_s1) && (bh_s1 <= ah_s1);
		f_s2.b_holds_a  <= (al_s1 >= bl_s1) && (ah_s1 <= bh_s1);
		f_s2.overlap    <= (bh_s1 >= al_s1) && (bl_s1 <= ah_s1);
		f_s2.a_is_point <= (al_s1 == ah_s1);
	end

	// divider lanes; non-divide data rides along as tag
	logic [TW-1:0] tag_in;
	assign tag_in = {op_s2, p0_s2, p1_s2, p2_s2, p3_s2, f_s2};
	logic [DW-1:0] q0, q1, q2, q3;
	logic [TW-1:0] tag_o, t1, t2, t3;
	logic dv0, dv1, dv2, dv3;
	logic [DW-1:0] bl_x, bh_x;
	assign bl_x = (bl_s2 == 0) ? DW'(1) : DW'(bl_s2);
	assign bh_x = (bh_s2 == 0) ? DW'(1) : DW'(bh_s2);

	iau_div #(.W(DW), .TW(TW)) u_div0 (.clk, .arst_n, .in_valid(v_s2),
		.num(DW'(al_s2)), .den(bl_x), .tag_in(tag_in),
		.out_valid(dv0), .quo(q0), .tag_out(tag_o));
	iau_div #(.W(DW), .TW(TW)) u_div1 (.clk, .arst_n, .in_valid(v_s2),
		.num(DW'(al_s2)), .den(bh_x), .tag_in(tag_in),
		.out_valid(dv1), .quo(q1), .tag_out(t1));
	iau_div #(.W(DW), .TW(TW)) u_div2 (.clk, .arst_n, .in_valid(v_s2),
		.num(DW'(ah_s2)), .den(bl_x), .tag_in(tag_in),
		.out_valid(dv2), .quo(q2), .tag_out(t2));
	iau_div #(.W(DW), .TW(TW)) u_div3 (.clk, .arst_n, .in_valid(v_s2),
		.num(DW'(ah_s2)), .den(bh_x), .tag_in(tag_in),
		.out_valid(dv3), .quo(q3), .tag_out(t3));

	logic [1:0] op_d;
	logic signed [RW-1:0] x0, x1, x2, x3, c0, c1, c2, c3;
	iau_pkg::flags_t f_d;
	assign {op_d, x0, x1, x2, x3, f_d} = tag_o;

	always_comb begin
		c0 = x0;
		c1 = x1;
		c2 = x2;
		c3 = x3;
		if (op_d == iau_pkg::OP_DIV) begin
			if (f_d.div_error) begin
				c0 = '0; c1 = '0; c2 = '0; c3 = '0;
			end else begin
				c0 = RW'(signed'(q0));
				c1 = RW'(signed'(q1));
				c2 = RW'(signed'(q2));
				c3 = RW'(signed'(q3));
			end
		end
	end

	iau_pkg::flags_t f_o;
	iau_span u_span (.clk, .arst_n, .in_valid(dv0 & dv1 & dv2 & dv3 & (t1 == t2) & (t2 == t3) | dv0),
		.v0(c0), .v1(c1), .v2(c2), .v3(c3), .flags_in(f_d),
		.out_valid(done), .lo(res_lo), .hi(res_hi), .flags_out(f_o));

	assign div_error  = f_o.div_error;
	assign a_holds_b  = f_o.a_holds_b;
	assign b_holds_a  = f_o.b_holds_a;
	assign overlap    = f_o.overlap;
	assign a_is_point = f_o.a_is_point;

`ifndef SYNTHESIS
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dv0 == dv3) else $error("divider lanes out of step");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_error |-> res_lo == 0 && res_hi == 0) else $error("error result not zero");
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res_lo <= res_hi) else $error("result interval reversed");
`endif
endmodule

@@ tb/sv/interval_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_arithmetic_unit_tb
// Self-checking bench: directed and random interval requests in several
// idle phases, each result compared with a local interval arithmetic model.
// ----------------------------------------------------------------------------
module interval_arithmetic_unit_tb;

	localparam int WATCHDOG = 2000;

	typedef struct {
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		iau_pkg::flags_t    fl;
	} interval_res_t;

	class interval_scoreboard;
		interval_res_t pending[$];
		int errors;
		int checked;

		function void note_request(iau_pkg::op_t code, logic signed [31:0] al_in,
				logic signed [31:0] ah_in, logic signed [31:0] bl_in,
				logic signed [31:0] bh_in);
			longint al, ah, bl, bh, t, mn, mx;
			longint q[4];
			interval_res_t r;
			al = al_in; ah = ah_in; bl = bl_in; bh = bh_in;
			if (ah < al) begin t = al; al = ah; ah = t; end
			if (bh < bl) begin t = bl; bl = bh; bh = t; end
			r.fl = '0;
			r.lo = 0;
			r.hi = 0;
			case (code)
				iau_pkg::OP_ADD: begin r.lo = al + bl; r.hi = ah + bh; end
				iau_pkg::OP_SUB: begin r.lo = al - bh; r.hi = ah - bl; end
				default: begin
					if (code == iau_pkg::OP_DIV && bl <= 0 && bh >= 0) begin
						r.fl.div_error = 1'b1;
					end else begin
						if (code == iau_pkg::OP_MUL) begin
							q[0] = al * bl; q[1] = al * bh; q[2] = ah * bl; q[3] = ah * bh;
						end else begin
							q[0] = al / bl; q[1] = al / bh; q[2] = ah / bl; q[3] = ah / bh;
						end
						mn = q[0]; mx = q[0];
						for (int k = 1; k < 4; k++) begin
							if (q[k] < mn) mn = q[k];
							if (q[k] > mx) mx = q[k];
						end
						r.lo = mn; r.hi = mx;
					end
				end
			endcase
			r.fl.a_holds_b  = (bl >= al && bh <= ah);
			r.fl.b_holds_a  = (al >= bl && ah <= bh);
			r.fl.overlap    = (bh >= al && bl <= ah);
			r.fl.a_is_point = (al == ah);
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [63:0] lo, logic signed [63:0] hi,
				iau_pkg::flags_t fl);
			interval_res_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (lo !== e.lo) begin
				$error("res_lo exp %0d got %0d", e.lo, lo); errors++;
			end
			if (hi !== e.hi) begin
				$error("res_hi exp %0d got %0d", e.hi, hi); errors++;
			end
			if (fl.div_error !== e.fl.div_error) begin
				$error("div_error exp %0b got %0b", e.fl.div_error, fl.div_error); errors++;
			end
			if (fl.a_holds_b !== e.fl.a_holds_b) begin
				$error("a_holds_b exp %0b got %0b", e.fl.a_holds_b, fl.a_holds_b); errors++;
			end
			if (fl.b_holds_a !== e.fl.b_holds_a) begin
				$error("b_holds_a exp %0b got %0b", e.fl.b_holds_a, fl.b_holds_a); errors++;
			end
			if (fl.overlap !== e.fl.overlap) begin
				$error("overlap exp %0b got %0b", e.fl.overlap, fl.overlap); errors++;
			end
			if (fl.a_is_point !== e.fl.a_is_point) begin
				$error("a_is_point exp %0b got %0b", e.fl.a_is_point, fl.a_is_point); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = '0;
	logic signed [31:0] a_lo = '0, a_hi = '0, b_lo = '0, b_hi = '0;
	logic done;
	logic signed [63:0] res_lo, res_hi;
	logic div_error, a_holds_b, b_holds_a, overlap, a_is_point;

	interval_scoreboard sb = new();
	int idle_pct;
	int sent;
	int quiet_cycles;

	interval_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.a_lo(a_lo), .a_hi(a_hi), .b_lo(b_lo), .b_hi(b_hi), .done(done),
		.res_lo(res_lo), .res_hi(res_hi), .div_error(div_error),
		.a_holds_b(a_holds_b), .b_holds_a(b_holds_a), .overlap(overlap),
		.a_is_point(a_is_point)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(res_lo, res_hi,
				{div_error, a_holds_b, b_holds_a, overlap, a_is_point});
			if ((start && !busy) || done) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("watchdog: no activity for %0d cycles", WATCHDOG);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Drive one request; start stays high across back-to-back requests.
	task automatic send_request(iau_pkg::op_t code, logic signed [31:0] al,
			logic signed [31:0] ah, logic signed [31:0] bl, logic signed [31:0] bh);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		op <= code; a_lo <= al; a_hi <= ah; b_lo <= bl; b_hi <= bh;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(code, al, ah, bl, bh);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_endpoint();
		case ($urandom_range(5))
			0: return 32'sh8000_0000 + $urandom_range(3);
			1: return 32'sh7fff_ffff - $urandom_range(3);
			2: return $signed($urandom_range(16)) - 8;
			3: return $signed($urandom_range(2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_request();
		iau_pkg::op_t code;
		logic signed [31:0] al, ah, bl;
		code = iau_pkg::op_t'($urandom_range(3));
		al = rand_endpoint();
		ah = ($urandom_range(3) == 0) ? al : rand_endpoint();
		bl = rand_endpoint();
		send_request(code, al, ah, bl, ($urandom_range(3) == 0) ? bl : rand_endpoint());
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (iau_pkg::DATA_WIDTH + 10) @(negedge clk);
	endtask

	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;

	initial begin
		quiet_cycles = 0;
		sent = 0;
		idle_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every op, reversed endpoints, zero divisor, points
		for (int c = 0; c < 4; c++) begin
			send_request(iau_pkg::op_t'(c), MINV, MINV, MINV, MINV);
			send_request(iau_pkg::op_t'(c), MAXV, MINV, -1, -1);
			send_request(iau_pkg::op_t'(c), 10, -3, 7, 2);
			send_request(iau_pkg::op_t'(c), 5, 5, -4, 4);
		end
		send_request(iau_pkg::OP_DIV, MINV, MINV, -1, -1);
		send_request(iau_pkg::OP_DIV, 7, 9, 0, 3);
		send_request(iau_pkg::OP_DIV, -7, 9, -3, 0);
		send_request(iau_pkg::OP_DIV, -7, 9, -3, -2);
		send_request(iau_pkg::OP_MUL, MAXV, MAXV, MAXV, MAXV);
		send_request(iau_pkg::OP_SUB, MINV, MINV, MAXV, MAXV);
		send_request(iau_pkg::OP_ADD, 0, 0, 0, 0);
		send_request(iau_pkg::OP_ADD, 3, 1, 2, 8);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 67 : (ph == 3) ? 25 : 0;
			repeat (207) random_request();
			drain();
		end

		$display("Sent %0d interval requests over four idle phases, %0d results checked.",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
